FILE: src/sts_pkg.sv
// Shared types and codes for the sorted table binary search block.
package sts_pkg;

	// Command codes carried by an input transaction
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Register index of the entry count on the configuration port
	localparam logic REG_ENTRY_COUNT = 1'b0;

	localparam int CountWidth = 11;

	typedef struct packed {
		logic               command;
		logic [9:0]         slot_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] search_key;
	} item_t;

	typedef struct packed {
		logic       found;
		logic [9:0] found_slot;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

endpackage

FILE: src/sts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
//
// Usage: items arrive on item with start; one is taken at a clock edge where
// start is high and busy is low. A load item (command 0) writes entry_value
// into slot slot_index of the table RAM in its accept cycle and gives no
// result; a slot at or beyond TABLE_DEPTH is dropped. A search item
// (command 1) runs a binary search over the first entry_count entries.
// The table must be loaded in ascending signed order for a meaningful answer.
// Timing: a search takes one probe per cycle through the read port of the
// table RAM, at most floor(log2(count)) + 1 probes for count entries, so 11
// for a full 1024-entry table. busy is high while the search probes the table, and the
// result shows on result with done for exactly one cycle, in the cycle after the
// last probe. With entry_count 0 the miss shows in the cycle after accept.
// A load leaves busy low, so loads may be issued back to back.
// The receiver cannot stall: each result is taken in its done cycle.
// Reset returns the controller to idle and clears entry_count; table contents
// are undefined until written. entry_count is written over the APB port at
// byte address 0; the user must write it only while the block is idle (the
// block does not enforce this); a count above TABLE_DEPTH is treated as TABLE_DEPTH.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sts_pkg::item_t item,
	output logic           done,
	output sts_pkg::result_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	import sts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > CountWidth) ? CW : CountWidth;

	state_t state_q, state_n;

	logic [CountWidth-1:0] entry_count_q;
	logic [CW-1:0]         lo_q, hi_q, mid_q;
	logic [CW-1:0]         lo_n, hi_n, mid_n;
	logic [CW-1:0]         count;
	logic [CW-1:0]         first_mid;
	logic                  accept;
	logic                  slot_ok;
	logic                  probe_eq, probe_gt, probe_more;
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [31:0]           ram_rdata;
	logic                  res_set, res_found;
	logic                  range_load;
	logic                  done_q;
	result_t               result_q;
	logic signed [31:0]    item_key_q;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT)) begin
			entry_count_q <= pwdata[CountWidth-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ENTRY_COUNT) begin
			prdata = 32'(entry_count_q);
		end
	end

	// Table RAM
	sts_ram #(
		.WIDTH (32),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(item.slot_index)),
		.wdata (item.entry_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Search datapath
	assign accept    = start && !busy;
	assign slot_ok   = 32'(item.slot_index) < 32'(TABLE_DEPTH);
	assign count     = (LW'(entry_count_q) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
	                                                           : CW'(entry_count_q);
	assign first_mid = (count - CW'(1)) >> 1;

	assign probe_eq   = $signed(ram_rdata) == item_key_q;
	assign probe_gt   = $signed(ram_rdata) > item_key_q;
	assign lo_n       = probe_gt ? lo_q : mid_q + CW'(1);
	assign hi_n       = probe_gt ? mid_q : hi_q;
	assign mid_n      = lo_n + ((hi_n - CW'(1) - lo_n) >> 1);
	assign probe_more = lo_n < hi_n;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.command == CMD_SEARCH) && (count != '0)) begin
					state_n = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (probe_eq || !probe_more) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Outputs of the controller
	always_comb begin
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = AW'(first_mid);
		res_set    = 1'b0;
		res_found  = 1'b0;
		range_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.command == CMD_LOAD) begin
						ram_we = slot_ok;
					end else if (count != '0) begin
						ram_re     = 1'b1;
						range_load = 1'b1;
					end else begin
						res_set = 1'b1;
					end
				end
			end
			ST_SEARCH: begin
				if (probe_eq) begin
					res_set   = 1'b1;
					res_found = 1'b1;
				end else if (probe_more) begin
					ram_re     = 1'b1;
					ram_raddr  = AW'(mid_n);
					range_load = 1'b1;
				end else begin
					res_set = 1'b1;
				end
			end
			default: begin
				res_set = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= res_set;
		end
	end

	// Search range and key; hold between probes
	always_ff @(posedge clk) begin
		if (range_load) begin
			if (state_q == ST_IDLE) begin
				lo_q  <= '0;
				hi_q  <= count;
				mid_q <= first_mid;
			end else begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
		end
		if (accept) begin
			item_key_q <= item.search_key;
		end
		if (res_set) begin
			result_q.found      <= res_found;
			result_q.found_slot <= res_found ? 10'(mid_q) : 10'd0;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: src/sts_checker.sv
// Port-level checker for the sorted table binary search block, with its bind.
module sts_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input sts_pkg::item_t   item,
	input logic             done,
	input sts_pkg::result_t result
);

	import sts_pkg::*;

	// A load gives no result and leaves the block free
	a_load_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.command == CMD_LOAD) |=> !done && !busy)
		else $error("load transaction produced a result or kept the block busy");

	// A search either starts probing or answers at once
	a_search_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.command == CMD_SEARCH) |=> busy || done)
		else $error("search transaction neither probed nor answered");

	// A result shows only once the search has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still searching");

	// A miss reports slot zero
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.found_slot == 10'd0)
		else $error("miss reported a nonzero slot");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

FILE: sim/sorted_table_binary_search_tb.sv
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;
	import sts_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int PHASE_ITEMS = 60;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       cmd_item = '0;
	logic        done;
	result_t     answer;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Table as the block should hold it, and as the stimulus has planned it
	logic signed [31:0] table_now [TABLE_DEPTH];
	logic signed [31:0] table_plan [TABLE_DEPTH];
	logic [10:0]        entry_count_cfg = '0;

	item_t   pending_items [$];
	result_t awaited_results [$];
	int      queued_count = 0;
	int      accepted_count = 0;
	int      errors = 0;
	int      gap_left = 0;
	logic    taken = 1'b0;
	logic    burst = 1'b0;

	sorted_table_binary_search #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(cmd_item),
		.done(done),
		.result(answer),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t binary_lookup(logic signed [31:0] key);
		result_t r;
		int lo;
		int hi;
		int mid;
		r = '0;
		lo = 0;
		hi = (entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg);
		while (lo < hi && !r.found) begin
			mid = lo + (hi - 1 - lo) / 2;
			if (table_now[mid] == key) begin
				r.found = 1'b1;
				r.found_slot = 10'(mid);
			end else if (table_now[mid] > key) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return burst ? 0 : $urandom_range(0, 18);
	endfunction

	// Present the next transaction at the falling edge; hold it until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && taken)
				gap_left = draw_gap();
			if (!(start && !taken)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cmd_item <= pending_items.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_results
		result_t want;
		if (arst_n) begin
			taken <= start && !busy;
			if (start && !busy) begin
				accepted_count++;
				if (cmd_item.command == CMD_LOAD)
					table_now[cmd_item.slot_index] = cmd_item.entry_value;
				else
					awaited_results.push_back(binary_lookup(cmd_item.search_key));
			end
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with no search outstanding");
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (answer.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, answer.found);
						errors++;
					end
					if (answer.found_slot !== want.found_slot) begin
						$error("found_slot: expected %0d, got %0d",
							want.found_slot, answer.found_slot);
						errors++;
					end
				end
			end
		end
	end

	task automatic queue_load(input int slot, input logic signed [31:0] value);
		item_t it;
		it.command = CMD_LOAD;
		it.slot_index = 10'(slot);
		it.entry_value = value;
		it.search_key = $urandom;
		table_plan[slot] = value;
		pending_items.push_back(it);
		queued_count++;
	endtask

	task automatic queue_search(input logic signed [31:0] key);
		item_t it;
		it.command = CMD_SEARCH;
		it.slot_index = 10'($urandom);
		it.entry_value = $urandom;
		it.search_key = key;
		pending_items.push_back(it);
		queued_count++;
	endtask

	// Mostly keys that sit in the searched span, some near misses and noise
	function automatic logic signed [31:0] pick_key();
		int span;
		int roll;
		logic signed [31:0] k;
		span = (entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg);
		roll = $urandom_range(0, 99);
		if (span > 0 && roll < 75) begin
			k = table_plan[$urandom_range(0, span - 1)];
			if (roll >= 60)
				k = $urandom_range(0, 1) ? k + 1 : k - 1;
		end else if (roll < 90) begin
			k = $urandom;
		end else begin
			case ($urandom_range(0, 3))
				0: k = VAL_MIN;
				1: k = VAL_MAX;
				2: k = 0;
				default: k = -1;
			endcase
		end
		return k;
	endfunction

	// Overwrite a slot, mostly keeping the order, sometimes breaking it
	task automatic queue_random_load();
		int span;
		int slot;
		longint lo;
		longint hi;
		logic signed [31:0] v;
		span = (entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg);
		if (span > 0 && $urandom_range(0, 9) < 7)
			slot = $urandom_range(0, span - 1);
		else
			slot = $urandom_range(0, TABLE_DEPTH - 1);
		lo = (slot > 0) ? longint'(table_plan[slot - 1]) : longint'(VAL_MIN);
		hi = (slot < TABLE_DEPTH - 1) ? longint'(table_plan[slot + 1]) : longint'(VAL_MAX);
		if (hi >= lo && $urandom_range(0, 4) != 0)
			v = 32'(lo + (longint'($urandom) % (hi - lo + 1)));
		else
			v = $urandom;
		queue_load(slot, v);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (accepted_count != queued_count || awaited_results.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_count(input int value);
		wait_idle();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {REG_ENTRY_COUNT, 2'b00};
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		entry_count_cfg = 11'(value);
		burst = ($urandom_range(0, 3) == 0);
		@(posedge clk);
	endtask

	initial begin
		int phase_counts [13];
		int cnt;
		longint acc;
		phase_counts = '{1024, 1, 0, 2047, 3, -1, 1023, 1025, 512, -1, 2, -2, 1024};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Empty table: every search misses; then loads and searches with small counts
		queue_search(VAL_MIN);
		queue_search(VAL_MAX);
		queue_load(0, VAL_MIN);
		queue_load(1, -1);
		queue_load(2, 0);
		queue_load(3, VAL_MAX);
		queue_load(TABLE_DEPTH - 1, 5);
		set_count(4);
		queue_search(VAL_MIN);
		queue_search(-1);
		queue_search(0);
		queue_search(VAL_MAX);
		queue_search(1);
		queue_search(-2);
		queue_search(VAL_MIN + 1);
		set_count(1);
		queue_search(VAL_MIN);
		queue_search(0);
		set_count(3);
		queue_search(VAL_MAX);
		queue_search(0);

		// Fill the whole table in ascending order, duplicates included
		wait_idle();
		@(posedge clk);
		acc = longint'(VAL_MIN) + $urandom_range(0, 1000);
		for (int s = 0; s < TABLE_DEPTH; s++) begin
			queue_load(s, (s == TABLE_DEPTH - 1) ? VAL_MAX : 32'(acc));
			if ($urandom_range(0, 7) != 0)
				acc += $urandom_range(1, 8_000_000);
			if (acc > longint'(VAL_MAX))
				acc = longint'(VAL_MAX);
			if ($urandom_range(0, 5) == 0)
				queue_search(pick_key());
		end

		foreach (phase_counts[p]) begin
			cnt = phase_counts[p];
			if (cnt == -1)
				cnt = $urandom_range(4, 1022);
			else if (cnt == -2)
				cnt = $urandom_range(1025, 2047);
			set_count(cnt);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 3) == 0)
					queue_random_load();
				else
					queue_search(pick_key());
			end
		end

		wait_idle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
